### rtl/tpsa_pkg.sv
// Shared types and constants for the transport stream PSI section assembler.
// Used by every module under rtl/; depends on nothing else.
`timescale 1ns / 1ps

package tpsa_pkg;

	localparam int PID_W       = 13;
	localparam int TID_W       = 8;
	localparam int CFG_DATA_W  = PID_W;
	localparam int SEC_LEN_W   = 13;
	localparam int MAP_ENTRIES = 256;
	localparam int MAP_IDX_W   = $clog2(MAP_ENTRIES);
	localparam int MAP_GROUP_N = 16;
	localparam int MAP_GROUP_W = MAP_ENTRIES / MAP_GROUP_N;
	localparam int GRP_IDX_W   = $clog2(MAP_GROUP_N);
	localparam int POS_IDX_W   = $clog2(MAP_GROUP_W);
	localparam int OUT_DATA_W  = 32;
	localparam int OUT_USER_W  = 2;

	localparam logic [7:0] PACKET_BYTES = 8'd188;
	localparam logic [7:0] TS_SYNC_MARK = 8'h47;
	localparam logic [5:0] VER_UNKNOWN  = 6'h20;

	typedef enum logic [1:0] {
		ST_COMPLETE_NEW  = 2'd0,
		ST_TABLE_FULL    = 2'd1,
		ST_VERSION_CHG   = 2'd2,
		ST_DISCARDED     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		AFC_RESERVED     = 2'd0,
		AFC_PAYLOAD_ONLY = 2'd1,
		AFC_ADAPT_ONLY   = 2'd2,
		AFC_ADAPT_PAYLD  = 2'd3
	} afc_t;

	typedef enum logic {
		REG_TARGET_PID      = 1'b0,
		REG_TARGET_TABLE_ID = 1'b1
	} reg_idx_t;

	// Seen-map update and lookup from the section control
	typedef struct packed {
		logic                 clr;
		logic                 set;
		logic [MAP_IDX_W-1:0] set_idx;
		logic [MAP_IDX_W-1:0] rd_idx;
	} map_req_t;

	// Seen-map answers: entry at rd_idx, and lowest unmarked entry (MAP_ENTRIES if none)
	typedef struct packed {
		logic               hit;
		logic [MAP_IDX_W:0] first_zero;
	} map_rsp_t;

	// One result of one stream byte
	typedef struct packed {
		logic                 has;
		logic                 byte_valid;
		logic [7:0]           section_byte;
		logic [SEC_LEN_W-1:0] byte_index;
		logic                 status_valid;
		status_t              status;
		logic [7:0]           sec_num;
	} step_res_t;

endpackage

### rtl/tpsa_seen_map.sv
// Seen-section bitmap with a two-stage registered search for the lowest unmarked entry.
// Depends on tpsa_pkg.
`timescale 1ns / 1ps

module tpsa_seen_map (
	input  logic               clk,
	input  logic               arst_n,
	input  tpsa_pkg::map_req_t req,
	output tpsa_pkg::map_rsp_t rsp
);
	import tpsa_pkg::*;

	logic [MAP_ENTRIES-1:0]                 map_q;
	logic [MAP_GROUP_N-1:0]                 grp_full_c;
	logic [MAP_GROUP_N-1:0][POS_IDX_W-1:0]  grp_pos_c;
	logic [MAP_GROUP_N-1:0]                 grp_full_s1;
	logic [MAP_GROUP_N-1:0][POS_IDX_W-1:0]  grp_pos_s1;
	logic [MAP_IDX_W:0]                     first_zero_c;
	logic [MAP_IDX_W:0]                     first_zero_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '0;
		end else if (req.clr) begin
			map_q <= '0;
		end else if (req.set) begin
			map_q[req.set_idx] <= 1'b1;
		end
	end

	// Per group: all marked, and lowest unmarked position
	always_comb begin
		for (int g = 0; g < MAP_GROUP_N; g++) begin
			grp_full_c[g] = &map_q[g*MAP_GROUP_W +: MAP_GROUP_W];
			grp_pos_c[g]  = '0;
			for (int b = MAP_GROUP_W - 1; b >= 0; b--) begin
				if (!map_q[g*MAP_GROUP_W + b]) begin
					grp_pos_c[g] = POS_IDX_W'(b);
				end
			end
		end
	end

	// Lowest group that still has a hole
	always_comb begin
		first_zero_c = (MAP_IDX_W+1)'(MAP_ENTRIES);
		for (int g = MAP_GROUP_N - 1; g >= 0; g--) begin
			if (!grp_full_s1[g]) begin
				first_zero_c = {1'b0, GRP_IDX_W'(g), grp_pos_s1[g]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_full_s1   <= '0;
			grp_pos_s1    <= '0;
			first_zero_s2 <= '0;
		end else begin
			grp_full_s1   <= grp_full_c;
			grp_pos_s1    <= grp_pos_c;
			first_zero_s2 <= first_zero_c;
		end
	end

	assign rsp.hit        = map_q[req.rd_idx];
	assign rsp.first_zero = first_zero_s2;

endmodule

### rtl/tpsa_section_ctrl.sv
// Packet filter and section assembly state: one stream byte per strobe, one result out.
// Depends on tpsa_pkg; talks to tpsa_seen_map through map_req_t / map_rsp_t.
`timescale 1ns / 1ps

module tpsa_section_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [7:0]                   stream_byte,
	input  logic                         packet_start,
	input  logic [tpsa_pkg::PID_W-1:0]   target_pid,
	input  logic [tpsa_pkg::TID_W-1:0]   target_table_id,
	input  tpsa_pkg::map_rsp_t           map_rsp,
	output tpsa_pkg::map_req_t           map_req,
	output tpsa_pkg::step_res_t          res
);
	import tpsa_pkg::*;

	logic [7:0]           pbc_q, pbc_d;
	logic                 acc_q, acc_d;
	logic                 usf_q, usf_d;
	logic [1:0]           afc_q, afc_d;
	logic [8:0]           poff_q, poff_d;
	logic                 coll_q, coll_d;
	logic [7:0]           htid_q, htid_d;
	logic [SEC_LEN_W-1:0] tsl_q, tsl_d;
	logic [4:0]           hver_q, hver_d;
	logic [7:0]           cur_q, cur_d;
	logic [7:0]           last_q, last_d;
	logic [SEC_LEN_W-1:0] sbc_q, sbc_d;
	logic [5:0]           sver_q, sver_d;

	logic                 skip;
	logic [7:0]           i;
	logic [SEC_LEN_W-1:0] k;
	logic                 emit;
	logic                 all_seen;
	logic                 bv, sv;
	status_t              st;

	always_comb begin
		pbc_d  = pbc_q;
		acc_d  = acc_q;
		usf_d  = usf_q;
		afc_d  = afc_q;
		poff_d = poff_q;
		coll_d = coll_q;
		htid_d = htid_q;
		tsl_d  = tsl_q;
		hver_d = hver_q;
		cur_d  = cur_q;
		last_d = last_q;
		sbc_d  = sbc_q;
		sver_d = sver_q;
		map_req        = '0;
		map_req.rd_idx = cur_q;
		bv   = 1'b0;
		sv   = 1'b0;
		st   = ST_COMPLETE_NEW;
		emit = 1'b0;
		k    = sbc_q;
		i    = packet_start ? 8'd0 : pbc_q;
		skip = !packet_start && (pbc_q >= PACKET_BYTES);
		all_seen = 1'b0;

		if (en && !skip) begin
			pbc_d = i + 8'd1;
			if (i == 8'd0) begin
				acc_d  = packet_start && (stream_byte == TS_SYNC_MARK);
				usf_d  = 1'b0;
				afc_d  = AFC_RESERVED;
				poff_d = '0;
			end else if (!acc_q) begin
				// packet not wanted: hold
			end else if (i == 8'd1) begin
				if (stream_byte[4:0] != target_pid[12:8]) begin
					acc_d = 1'b0;
				end else begin
					usf_d = stream_byte[6];
				end
			end else if (i == 8'd2) begin
				if (stream_byte != target_pid[7:0]) begin
					acc_d = 1'b0;
				end
			end else if (i == 8'd3) begin
				afc_d = stream_byte[5:4];
				unique case (afc_t'(stream_byte[5:4]))
					AFC_PAYLOAD_ONLY: poff_d = 9'd4;
					AFC_ADAPT_PAYLD:  poff_d = 9'd5;
					default:          acc_d  = 1'b0;
				endcase
				// new unit start aborts the section in progress
				if (acc_d && usf_q && coll_q) begin
					coll_d = 1'b0;
					sv     = 1'b1;
					st     = ST_DISCARDED;
				end
			end else if (i == 8'd4 && afc_q == AFC_ADAPT_PAYLD) begin
				poff_d = 9'd5 + {1'b0, stream_byte};
			end else if ({1'b0, i} >= poff_q) begin
				if (usf_q) begin
					// pointer field: skip it and open a new section
					poff_d = {1'b0, i} + 9'd1 + {1'b0, stream_byte};
					usf_d  = 1'b0;
					coll_d = 1'b1;
					sbc_d  = '0;
				end else if (coll_q) begin
					emit = 1'b1;
					if (k == 13'd0) begin
						htid_d = stream_byte;
						if (stream_byte != target_table_id) begin
							coll_d = 1'b0;
							emit   = 1'b0;
						end
					end else if (k == 13'd1) begin
						tsl_d = {1'b0, stream_byte[3:0], 8'h00};
					end else if (k == 13'd2) begin
						tsl_d = (tsl_q | {5'b0, stream_byte}) + 13'd3;
						if (tsl_d < 13'd8) begin
							coll_d = 1'b0;
							sv     = 1'b1;
							st     = ST_DISCARDED;
						end
					end else if (k == 13'd5) begin
						hver_d = stream_byte[5:1];
					end else if (k == 13'd6) begin
						cur_d = stream_byte;
					end else if (k == 13'd7) begin
						last_d = stream_byte;
					end

					all_seen = map_rsp.first_zero > {1'b0, last_d};

					if (k == 13'd7) begin
						if (!sver_q[5] && (sver_q[4:0] != hver_q)) begin
							map_req.clr = 1'b1;
							sver_d = VER_UNKNOWN;
							coll_d = 1'b0;
							sv     = 1'b1;
							st     = ST_VERSION_CHG;
						end else if (!all_seen && map_rsp.hit) begin
							coll_d = 1'b0;
							sv     = 1'b1;
							st     = ST_DISCARDED;
						end
					end

					if (emit) begin
						bv    = 1'b1;
						sbc_d = k + 13'd1;
						if (coll_d && k >= 13'd7 &&
							({1'b0, k} + 14'd1) >= {1'b0, tsl_d}) begin
							coll_d = 1'b0;
							sv     = 1'b1;
							if (all_seen) begin
								st = ST_TABLE_FULL;
							end else begin
								map_req.set     = 1'b1;
								map_req.set_idx = cur_d;
								st = ST_COMPLETE_NEW;
							end
							sver_d = {1'b0, hver_d};
						end
					end
				end
			end
		end

		res.has          = bv || sv;
		res.byte_valid   = bv;
		res.section_byte = bv ? stream_byte : 8'd0;
		res.byte_index   = bv ? k : '0;
		res.status_valid = sv;
		res.status       = sv ? st : ST_COMPLETE_NEW;
		res.sec_num      = cur_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pbc_q  <= '0;
			acc_q  <= 1'b0;
			usf_q  <= 1'b0;
			afc_q  <= '0;
			poff_q <= '0;
			coll_q <= 1'b0;
			htid_q <= '0;
			tsl_q  <= '0;
			hver_q <= '0;
			cur_q  <= '0;
			last_q <= '0;
			sbc_q  <= '0;
			sver_q <= VER_UNKNOWN;
		end else begin
			pbc_q  <= pbc_d;
			acc_q  <= acc_d;
			usf_q  <= usf_d;
			afc_q  <= afc_d;
			poff_q <= poff_d;
			coll_q <= coll_d;
			htid_q <= htid_d;
			tsl_q  <= tsl_d;
			hver_q <= hver_d;
			cur_q  <= cur_d;
			last_q <= last_d;
			sbc_q  <= sbc_d;
			sver_q <= sver_d;
		end
	end

endmodule

### rtl/ts_psi_section_assembler.sv
// Top level of the transport stream PSI section assembler: stream ports, config
// registers, input and result registers. Depends on tpsa_pkg, tpsa_seen_map, tpsa_section_ctrl.
`timescale 1ns / 1ps

// Usage
//   Slave stream: one transport stream byte per transfer in s_tdata, with s_tuser
//   high on the first byte of each 188-byte packet. Master stream: one transfer per
//   section byte and/or section outcome; bytes of filtered packets that carry
//   nothing give no transfer.
//   Configure target_pid (index 0) and target_table_id (index 1) through the write
//   port while the stream is idle; a write lands on the clock edge with cfg_wr_en.
//   A result passes the input register, then the result register, before it is on
//   m_tvalid. Throughput: one byte per cycle while no stall on m_tready holds the pipe,
//   set by the single pass of per-byte control logic between the two registers.
//   The lowest-unmarked search over the 256-entry seen map runs in a two-stage
//   registered tree in the background; it settles well before the next section
//   header can need it.
//   Stall: while m_tready is low and a result waits, the input register holds and
//   s_tready drops once it is full; no byte is lost or repeated.
//   Reset: arst_n clears all control state, the seen map and the stored version
//   (marked unknown); both config registers read zero.

module ts_psi_section_assembler (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write port
	input  logic                                cfg_wr_en,
	input  logic                                cfg_addr,
	input  logic [tpsa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	// slave stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // [7:0] stream_byte
	input  logic [0:0]                          s_tuser,   // [0] packet_start
	// master stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [7:0] section_byte, [20:8] byte_index, [22:21] status,
	// [30:23] sec_num, [31] zero
	output logic [tpsa_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic [tpsa_pkg::OUT_USER_W-1:0]     m_tuser    // [0] byte_valid, [1] status_valid
);
	import tpsa_pkg::*;

	logic [PID_W-1:0] target_pid_q;
	logic [TID_W-1:0] target_table_id_q;

	logic       in_valid_s1;
	logic [7:0] in_byte_s1;
	logic       in_start_s1;

	logic       out_valid_q;
	step_res_t  out_res_q;

	logic       advance;
	logic       step_en;
	step_res_t  step_res;
	map_req_t   map_req;
	map_rsp_t   map_rsp;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_pid_q      <= '0;
			target_table_id_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_TARGET_PID:      target_pid_q      <= cfg_wdata;
				REG_TARGET_TABLE_ID: target_table_id_q <= cfg_wdata[TID_W-1:0];
				default:             target_pid_q      <= target_pid_q;
			endcase
		end
	end

	// Advance the pipe whenever the result register is free or being drained
	assign advance  = !out_valid_q || m_tready;
	assign step_en  = in_valid_s1 && advance;
	assign s_tready = !in_valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_byte_s1  <= s_tdata;
			in_start_s1 <= s_tuser[0];
		end
	end

	tpsa_section_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (step_en),
		.stream_byte     (in_byte_s1),
		.packet_start    (in_start_s1),
		.target_pid      (target_pid_q),
		.target_table_id (target_table_id_q),
		.map_rsp         (map_rsp),
		.map_req         (map_req),
		.res             (step_res)
	);

	tpsa_seen_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (map_req),
		.rsp    (map_rsp)
	);

	// Result register: load on every advance, drop bytes that carry nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step_en && step_res.has;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && step_res.has && advance) begin
			out_res_q <= step_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_res_q.sec_num, out_res_q.status,
	                   out_res_q.byte_index, out_res_q.section_byte};
	assign m_tuser  = {out_res_q.status_valid, out_res_q.byte_valid};

	// A transfer always carries a section byte, an outcome, or both
	a_result_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[0] || m_tuser[1]))
		else $error("result transfer carries neither byte nor status");

	// The first byte of an emitted section is the configured table id
	a_first_byte_tid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0] && m_tdata[20:8] == '0) |-> (m_tdata[7:0] == target_table_id_q))
		else $error("section byte 0 differs from target table id");

	// An outcome that comes with a byte is only decided at header byte 2 or later
	a_status_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0] && m_tuser[1]) |-> (m_tdata[20:8] >= 13'd2))
		else $error("section outcome reported on too early a byte");

	// A byte held in the input register moves on once the result side is free
	a_input_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !out_valid_q && !(s_tvalid && s_tready)) |=> !in_valid_s1)
		else $error("input register held with result register free");

endmodule
